FILE: src/frame_header_and_error_checker_top_macros.svh
// Assertion macros shared by the frame checker RTL.
`ifndef FRAME_HEADER_AND_ERROR_CHECKER_TOP_MACROS_SVH
`define FRAME_HEADER_AND_ERROR_CHECKER_TOP_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define FHEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define FHEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fhec_pkg.sv
// Shared types, codes and the CRC byte step for the frame checker.
`default_nettype none
package fhec_pkg;

  // Position class of a byte within its frame
  localparam logic [1:0] KIND_HDR0 = 2'd0;
  localparam logic [1:0] KIND_HDR1 = 2'd1;
  localparam logic [1:0] KIND_HDR2 = 2'd2;
  localparam logic [1:0] KIND_BODY = 2'd3;

  // Error mode codes from the trailer
  localparam logic [1:0] MODE_PARITY   = 2'd0;
  localparam logic [1:0] MODE_CRC      = 2'd1;
  localparam logic [1:0] MODE_CHECKSUM = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_OK   = 2'd1;
  localparam logic [1:0] VERDICT_BAD  = 2'd2;

  // Fixed frame overhead: three header bytes plus the trailer
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

  // Classified byte handed from the front end to the back end
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       odd_pos;
    logic       last;
  } mid_item_t;

  // One decoded frame result
  typedef struct packed {
    logic [1:0]  language;
    logic [6:0]  payload_bytes;
    logic [1:0]  source_group;
    logic [5:0]  source_number;
    logic [1:0]  dest_group;
    logic [5:0]  dest_number;
    logic [1:0]  routing;
    logic [1:0]  flow_control;
    logic [1:0]  error_mode;
    logic        odd_flag;
    logic [1:0]  verdict;
    logic [15:0] check_value;
  } result_t;

  // Advance a CRC-8 register over one byte, MSB first, augmented
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                          input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] r;
    logic       top;
    r = crc_in;
    for (int n = 0; n < 8; n++) begin
      top = r[7];
      r   = {r[6:0], data[7-n]};
      if (top) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/fhec_fifo.sv
// Small synchronous queue with full and empty flags decoded from a registered count.
`default_nettype none
module fhec_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/fhec_front.sv
// Front end: accepts frame bytes and tags each with its place in the frame.
`default_nettype none
module fhec_front import fhec_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] frame_byte,
  input  wire logic       mid_full,
  output logic            mid_push,
  output mid_item_t       mid_item
);

  logic [7:0] byte_position;
  logic [7:0] byte_position_next;
  logic [7:0] frame_length;
  logic [7:0] frame_length_next;
  logic       is_last;

  assign mid_push = push && !mid_full;

  // Classify the current byte and work out the frame end
  always_comb begin
    if (byte_position == '0) begin
      frame_length_next = {1'b0, frame_byte[5:0], 1'b0} + FRAME_OVERHEAD;
    end else begin
      frame_length_next = frame_length;
    end
    is_last            = (byte_position + 8'd1) >= frame_length_next;
    byte_position_next = is_last ? '0 : byte_position + 8'd1;

    mid_item.data    = frame_byte;
    mid_item.odd_pos = byte_position[0];
    mid_item.last    = is_last;
    case (byte_position)
      8'd0:    mid_item.kind = KIND_HDR0;
      8'd1:    mid_item.kind = KIND_HDR1;
      8'd2:    mid_item.kind = KIND_HDR2;
      default: mid_item.kind = KIND_BODY;
    endcase
  end

  // Advance the frame position on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_length  <= '0;
    end else if (mid_push) begin
      byte_position <= byte_position_next;
      frame_length  <= is_last ? '0 : frame_length_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/fhec_back.sv
// Back end: runs parity, CRC-8 and checksum, and forms the frame result.
`default_nettype none
module fhec_back import fhec_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  input  wire mid_item_t  mid_item,
  input  wire logic       mid_empty,
  output logic            mid_pop,
  input  wire logic       res_full,
  output logic            res_push,
  output result_t         result
);

  logic [7:0]  crc_polynomial;
  logic [23:0] header_fields;
  logic        parity_accum;
  logic [7:0]  crc_register;
  logic [15:0] sum_accum;
  logic [7:0]  high_byte_hold;

  logic        parity_next;
  logic [7:0]  crc_next;
  logic [16:0] pair_sum;
  logic [15:0] sum_next;
  logic [7:0]  b;

  assign b        = mid_item.data;
  assign mid_pop  = !mid_empty && (!mid_item.last || !res_full);
  assign res_push = mid_pop && mid_item.last;

  // Update the running checks with the current byte
  always_comb begin
    parity_next = parity_accum ^ (^b);
    crc_next    = crc_byte(crc_register, b, crc_polynomial);
    pair_sum    = {1'b0, sum_accum} + {1'b0, high_byte_hold, b};
    sum_next    = pair_sum[15:0] + {15'd0, pair_sum[16]};
  end

  // Form the result from header, trailer and final check values
  always_comb begin
    result.language      = header_fields[23:22];
    result.payload_bytes = {header_fields[21:16], 1'b0};
    result.source_group  = header_fields[15:14];
    result.source_number = header_fields[13:8];
    result.dest_group    = header_fields[7:6];
    result.dest_number   = header_fields[5:0];
    result.routing       = b[7:6];
    result.flow_control  = b[5:4];
    result.error_mode    = b[3:2];
    result.odd_flag      = b[1];
    result.verdict       = VERDICT_NONE;
    result.check_value   = '0;
    case (b[3:2])
      MODE_PARITY: begin
        result.verdict = (b[1] == parity_next) ? VERDICT_OK : VERDICT_BAD;
      end
      MODE_CRC: begin
        if (!b[1]) begin
          result.check_value = {8'd0, crc_next};
        end
      end
      MODE_CHECKSUM: begin
        result.check_value = ~sum_next;
      end
      default: begin
        result.check_value = '0;
      end
    endcase
  end

  // Hold the CRC polynomial register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= 8'h07;
    end else if (cfg_valid) begin
      crc_polynomial <= cfg_data;
    end
  end

  // Advance per-frame state; clear it after the trailer
  always_ff @(posedge clk) begin
    if (rst) begin
      header_fields  <= '0;
      parity_accum   <= 1'b0;
      crc_register   <= '0;
      sum_accum      <= '0;
      high_byte_hold <= '0;
    end else if (mid_pop) begin
      if (mid_item.last) begin
        header_fields  <= '0;
        parity_accum   <= 1'b0;
        crc_register   <= '0;
        sum_accum      <= '0;
        high_byte_hold <= '0;
      end else begin
        parity_accum <= parity_next;
        crc_register <= crc_next;
        if (mid_item.odd_pos) begin
          sum_accum <= sum_next;
        end else begin
          high_byte_hold <= b;
        end
        case (mid_item.kind)
          KIND_HDR0: header_fields       <= {b, 16'd0};
          KIND_HDR1: header_fields[15:8] <= b;
          KIND_HDR2: header_fields[7:0]  <= b;
          default:   header_fields       <= header_fields;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/frame_header_and_error_checker_top.sv
// Frame header decoder and parity / CRC-8 / checksum checker, top level.
//
// Input side is a queue write port: a frame byte is taken at a clock edge
// with push high and full low, header bytes first and the trailer last.
// Results come out of a queue read port: while empty is low the oldest
// frame result sits on the field ports, and pop with empty low takes it.
// One result appears per frame, after its trailer byte.
// Throughput is one byte per cycle while full is low; the CRC-8 advances a
// whole byte at a time and the checksum adds each byte pair in the back end.
// With no older bytes queued, the trailer passes the byte queue and then the
// result queue; empty goes low once the back end has pushed the result.
// If the result queue fills, the back end holds the trailer, the byte
// queue fills behind it and full rises; nothing is dropped.
// The polynomial register takes a write whenever cfg_valid is high
// (cfg_ready is always high) and applies to bytes processed afterwards.
// Synchronous reset empties both queues, clears the frame state and sets
// the polynomial to 0x07; the next byte is taken as a header byte.
`default_nettype none
`include "frame_header_and_error_checker_top_macros.svh"
module frame_header_and_error_checker_top import fhec_pkg::*; #(
  parameter int MID_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  crc_polynomial,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       language,
  output logic [6:0]       payload_bytes,
  output logic [1:0]       source_group,
  output logic [5:0]       source_number,
  output logic [1:0]       dest_group,
  output logic [5:0]       dest_number,
  output logic [1:0]       routing,
  output logic [1:0]       flow_control,
  output logic [1:0]       error_mode,
  output logic             odd_flag,
  output logic [1:0]       verdict,
  output logic [15:0]      check_value
);

  mid_item_t front_item;
  mid_item_t back_item;
  logic      mid_push;
  logic      mid_full;
  logic      mid_pop;
  logic      mid_empty;
  logic      res_push;
  logic      res_full;
  result_t   back_result;
  result_t   out_result;

  assign cfg_ready = 1'b1;
  assign full      = mid_full;

  // Tag incoming bytes
  fhec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .frame_byte (frame_byte),
    .mid_full   (mid_full),
    .mid_push   (mid_push),
    .mid_item   (front_item)
  );

  // Decouple front and back
  fhec_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (front_item),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (back_item),
    .empty   (mid_empty)
  );

  // Run the checks and build results
  fhec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (crc_polynomial),
    .mid_item  (back_item),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .result    (back_result)
  );

  // Hold finished results until taken
  fhec_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (back_result),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_result),
    .empty   (empty)
  );

  // Unpack the result onto the field ports
  assign language      = out_result.language;
  assign payload_bytes = out_result.payload_bytes;
  assign source_group  = out_result.source_group;
  assign source_number = out_result.source_number;
  assign dest_group    = out_result.dest_group;
  assign dest_number   = out_result.dest_number;
  assign routing       = out_result.routing;
  assign flow_control  = out_result.flow_control;
  assign error_mode    = out_result.error_mode;
  assign odd_flag      = out_result.odd_flag;
  assign verdict       = out_result.verdict;
  assign check_value   = out_result.check_value;

  // Back end never writes into a full result queue
  `FHEC_ASSERT_SAME(a_res_no_overflow, clk, rst, res_push, !res_full, "result queue overflow")
  // Back end only consumes a byte that is present
  `FHEC_ASSERT_SAME(a_mid_pop_valid, clk, rst, mid_pop, !mid_empty, "byte queue underflow")
  // A result is produced only for a trailer byte
  `FHEC_ASSERT_SAME(a_res_on_trailer, clk, rst, res_push, back_item.last, "result without trailer")

endmodule
`default_nettype wire
